// File: design/lsr_pkg.sv
// Shared types and constants for the line segment rasteriser.
// No dependencies; used by lsr_ctrl, lsr_datapath and line_segment_rasterizer_top.
package lsr_pkg;

    localparam int COORD_W   = 5;   // grid coordinate width
    localparam int DIV_STEPS = 6;   // divider cycles, two quotient bits each

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               last_pixel;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;         // capture segment, form line coefficients
        logic start_point;  // single-point segment
        logic start_sweep;  // open a sweep
        logic sweep_row;    // 0: column sweep, 1: row sweep
        logic i_inc;        // next column/row
        logic prep;         // form dividend and divisor
        logic div_step;     // two restoring division steps
        logic pend_load;    // candidate pixel into pending slot
        logic pend_clear;   // pending slot emptied
        logic out_load;     // pending pixel into output register
        logic out_last;     // last flag for that load
    } lsr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic ca_zero;
        logic cb_zero;
        logic sweep_row;
        logic point;
        logic i_done;
        logic cand_ok;
        logic pend_valid;
        logic out_free;
    } lsr_status_t;

endpackage

// File: design/lsr_datapath.sv
// Datapath of the line segment rasteriser: coefficients, sweep counter, divider,
// pending pixel and output register. Depends on lsr_pkg.
module lsr_datapath #(
    parameter int GRID_WIDTH  = 32,
    parameter int GRID_HEIGHT = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lsr_pkg::in_item_t    s_item,
    input  lsr_pkg::lsr_cmd_t    cmd,
    output lsr_pkg::lsr_status_t status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lsr_pkg::out_item_t   m_item
);

    localparam int CW = lsr_pkg::COORD_W;
    localparam logic [11:0] GW = 12'(GRID_WIDTH);
    localparam logic [11:0] GH = 12'(GRID_HEIGHT);

    logic [CW-1:0]      ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [5:0]  ca_reg, cb_reg;
    logic signed [11:0] cc_reg;
    logic               point_reg, row_reg;
    logic [CW-1:0]      i_reg, hi_reg;
    logic [11:0]        dq_reg, dq_next;
    logic [5:0]         rem_reg, rem_next;
    logic [5:0]         dvs_reg;
    logic               neg_reg;
    logic [CW-1:0]      pend_x_reg, pend_y_reg;
    logic               pend_valid_reg, pend_valid_next;
    logic               m_valid_reg, m_valid_next;
    lsr_pkg::out_item_t m_item_reg;

    // setup arithmetic
    logic [9:0]         prod_a, prod_b;
    // sweep bounds
    logic [CW-1:0]      lo_w, hi_w;
    // dividend formation
    logic signed [5:0]  coef_w, den_w;
    logic signed [11:0] term_w;
    logic signed [12:0] num_w;
    logic [11:0]        abs_num_w;
    logic [4:0]         abs_den_w;
    // candidate pixel
    logic               q_neg;
    logic [CW-1:0]      cand_x, cand_y;
    logic               cand_ok;
    logic               out_free;

    assign prod_a = 10'(s_item.start_x) * 10'(s_item.end_y);
    assign prod_b = 10'(s_item.start_y) * 10'(s_item.end_x);

    always_comb begin
        if (cmd.sweep_row) begin
            lo_w = (ay_reg < by_reg) ? ay_reg : by_reg;
            hi_w = (ay_reg < by_reg) ? by_reg : ay_reg;
        end else begin
            lo_w = (ax_reg < bx_reg) ? ax_reg : bx_reg;
            hi_w = (ax_reg < bx_reg) ? bx_reg : ax_reg;
        end
    end

    // column sweep: (C - A*x)/B, row sweep: (C - B*y)/A
    assign coef_w    = row_reg ? cb_reg : ca_reg;
    assign den_w     = row_reg ? ca_reg : cb_reg;
    assign term_w    = coef_w * $signed({1'b0, i_reg});
    assign num_w     = 13'(cc_reg) - 13'(term_w);
    assign abs_num_w = num_w[12] ? 12'(-num_w) : 12'(num_w);
    assign abs_den_w = den_w[5] ? 5'(-den_w) : 5'(den_w);

    // two restoring steps per cycle
    always_comb begin
        logic [6:0]  t;
        logic [5:0]  r;
        logic [11:0] d;
        r = rem_reg;
        d = dq_reg;
        for (int k = 0; k < 2; k++) begin
            t = {r, d[11]};
            d = {d[10:0], 1'b0};
            if (t >= {1'b0, dvs_reg}) begin
                t    = t - {1'b0, dvs_reg};
                d[0] = 1'b1;
            end
            r = t[5:0];
        end
        rem_next = r;
        dq_next  = d;
    end

    assign q_neg = neg_reg && (dq_reg != 12'd0);

    always_comb begin
        if (point_reg) begin
            cand_x  = ax_reg;
            cand_y  = ay_reg;
            cand_ok = (12'(ax_reg) < GW) && (12'(ay_reg) < GH);
        end else if (row_reg) begin
            cand_x  = dq_reg[CW-1:0];
            cand_y  = i_reg;
            cand_ok = !q_neg && (dq_reg < GW) && (12'(i_reg) < GH);
        end else begin
            cand_x  = i_reg;
            cand_y  = dq_reg[CW-1:0];
            cand_ok = !q_neg && (12'(i_reg) < GW) && (dq_reg < GH);
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        pend_valid_next = pend_valid_reg;
        if (cmd.pend_load) begin
            pend_valid_next = 1'b1;
        end else if (cmd.pend_clear) begin
            pend_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ax_reg <= s_item.start_x;
            ay_reg <= s_item.start_y;
            bx_reg <= s_item.end_x;
            by_reg <= s_item.end_y;
            ca_reg <= $signed({1'b0, s_item.end_y}) - $signed({1'b0, s_item.start_y});
            cb_reg <= $signed({1'b0, s_item.start_x}) - $signed({1'b0, s_item.end_x});
            cc_reg <= $signed({2'b00, prod_a}) - $signed({2'b00, prod_b});
        end
        if (cmd.start_point) begin
            point_reg <= 1'b1;
        end else if (cmd.start_sweep) begin
            point_reg <= 1'b0;
        end
        if (cmd.start_sweep) begin
            row_reg <= cmd.sweep_row;
            i_reg   <= lo_w;
            hi_reg  <= hi_w;
        end else if (cmd.i_inc) begin
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.prep) begin
            // |num| never exceeds 31*31, so doubling fits in 12 bits
            dq_reg  <= 12'({abs_num_w, 1'b0}) + 12'(abs_den_w);
            rem_reg <= '0;
            dvs_reg <= {abs_den_w, 1'b0};
            neg_reg <= num_w[12] ^ den_w[5];
        end else if (cmd.div_step) begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
        if (cmd.pend_load) begin
            pend_x_reg <= cand_x;
            pend_y_reg <= cand_y;
        end
        if (cmd.out_load) begin
            m_item_reg.pixel_x    <= pend_x_reg;
            m_item_reg.pixel_y    <= pend_y_reg;
            m_item_reg.last_pixel <= cmd.out_last;
        end
    end

    assign status.ca_zero    = (ca_reg == 6'sd0);
    assign status.cb_zero    = (cb_reg == 6'sd0);
    assign status.sweep_row  = row_reg;
    assign status.point      = point_reg;
    assign status.i_done     = (i_reg == hi_reg);
    assign status.cand_ok    = cand_ok;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// File: design/lsr_ctrl.sv
// Controller state machine of the line segment rasteriser.
// Depends on lsr_pkg; drives lsr_datapath through command and status structs.
module lsr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lsr_pkg::lsr_status_t status,
    output lsr_pkg::lsr_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_PREP  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;

    localparam int CNT_W = $clog2(lsr_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(lsr_pkg::DIV_STEPS - 1);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             stall;

    assign s_ready = (state_reg == ST_IDLE);
    // a fresh pixel must wait while the pending one cannot leave
    assign stall   = status.cand_ok && status.pend_valid && !status.out_free;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (status.ca_zero && status.cb_zero) begin
                    cmd.start_point = 1'b1;
                    state_next      = ST_CHECK;
                end else begin
                    cmd.start_sweep = 1'b1;
                    cmd.sweep_row   = status.cb_zero;
                    state_next      = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!stall) begin
                    if (status.cand_ok) begin
                        cmd.pend_load = 1'b1;
                        cmd.out_load  = status.pend_valid;
                    end
                    priority if (status.point) begin
                        state_next = ST_FLUSH;
                    end else if (!status.i_done) begin
                        cmd.i_inc  = 1'b1;
                        state_next = ST_PREP;
                    end else if (!status.sweep_row && !status.ca_zero) begin
                        cmd.start_sweep = 1'b1;
                        cmd.sweep_row   = 1'b1;
                        state_next      = ST_PREP;
                    end else begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!status.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_last   = 1'b1;
                    cmd.pend_clear = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: design/line_segment_rasterizer_top.sv
// Top level of the line segment rasteriser: controller plus datapath.
// Depends on lsr_pkg, lsr_ctrl and lsr_datapath.
//
// Use: one s_ transaction carries a segment (two endpoints). The block forms
// the line A*x + B*y = C, sweeps every column between the endpoints and then
// every row, and returns one m_ transaction per pixel, rounded half away from
// zero; last_pixel marks the final pixel of the segment. A sweep with a zero
// divisor is skipped; a single-point segment gives its one pixel; pixels off
// the GRID_WIDTH x GRID_HEIGHT grid are dropped, so a segment may give none.
// Each swept pixel passes through dividend set-up, a two-bit-per-cycle
// restoring divider and a check; a segment sweeps at most 64 pixels. One
// pixel is held back so that the last flag is known before it leaves.
// s_ready is high only between segments; the final pixel may still sit in
// the output register while the next segment is taken.
// A stalled receiver (m_ready low) holds the output register and freezes the
// sweep at its check cycle; nothing is dropped.
// Reset (aresetn low at a clock edge) returns to idle and empties the output
// register and the pending slot.
module line_segment_rasterizer_top #(
    parameter int GRID_WIDTH  = 32,
    parameter int GRID_HEIGHT = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lsr_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output lsr_pkg::out_item_t m_item
);

    lsr_pkg::lsr_cmd_t    cmd;
    lsr_pkg::lsr_status_t status;

    // sequencing: one segment at a time
    lsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic, divider and output register
    lsr_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
